@@ rtl/stc_pkg.sv @@
// shared types, constants and the quarter-wave sine table for the tone generator
package stc_pkg;

  localparam int unsigned MAX_CHUNK       = 64;
  localparam int unsigned CNT_W           = $clog2(MAX_CHUNK + 1);
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QTAB_SIZE       = (1 << SINE_TABLE_BITS) + 1;
  localparam int unsigned QA_W            = SINE_TABLE_BITS + 1;
  localparam int unsigned MAG_W           = 15;
  localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_LEN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN    = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMPTY
  } stc_state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic issue_empty;
  } stc_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic cnt_last;
    logic advance;
  } stc_sts_t;

  typedef logic [MAG_W-1:0] qw_tab_t [QTAB_SIZE];

  // shift and subtract long division, only used while the table is built
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 taylor sum through x^13, scaled to Q15 with half-up rounding
  function automatic qw_tab_t build_qw();
    qw_tab_t            t;
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] d;
    logic        [63:0] v;
    logic signed [63:0] sum;
    for (int k = 0; k < QTAB_SIZE; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 6; n++) begin
        d    = 64'((2 * n) * (2 * n + 1));
        term = udiv64((term * x2) >> 30, d);
        if ((n & 1) == 1) sum = sum - signed'(term);
        else              sum = sum + signed'(term);
      end
      if (sum < 0) sum = '0;
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      t[k] = v[MAG_W-1:0];
    end
    return t;
  endfunction

endpackage

@@ rtl/stc_sine_rom.sv @@
// quarter-wave sine magnitude rom with registered read
module stc_sine_rom (
  input  logic                      clk,
  input  logic                      en,
  input  logic [stc_pkg::QA_W-1:0]  addr,
  output logic [stc_pkg::MAG_W-1:0] data
);
  import stc_pkg::*;

  localparam qw_tab_t QW_TAB = build_qw();

  logic [MAG_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= QW_TAB[addr];
    end
  end

  assign data = data_r;

endmodule

@@ rtl/stc_ctrl.sv @@
// chunk sequencer: accepts requests and paces sample issue
module stc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_chunk_request,
  input  stc_pkg::stc_sts_t sts,
  output stc_pkg::stc_cmd_t cmd
);
  import stc_pkg::*;

  stc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        // a request word with the bit clear is taken and dropped
        if (in_valid && in_chunk_request) begin
          cmd.start = 1'b1;
          state_nxt = sts.rem_zero ? ST_EMPTY : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = sts.advance;
        if (sts.advance && sts.cnt_last) state_nxt = ST_IDLE;
      end
      ST_EMPTY: begin
        cmd.issue_empty = sts.advance;
        if (sts.advance) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/stc_dp.sv @@
// config registers, phase accumulator, stream counter and sample pipeline
module stc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  stc_pkg::stc_cmd_t             cmd,
  output stc_pkg::stc_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_sample,
  output logic                          out_sample_valid,
  output logic                          out_last_of_chunk,
  output logic                          out_end_of_stream
);
  import stc_pkg::*;

  logic [31:0]      inc_r, start_r, len_r;
  logic [6:0]       clen_r;
  logic [31:0]      phase_r, rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             eos_r;

  // stage a: rom read in flight
  logic             a_vld_r, a_neg_r, a_sv_r, a_last_r, a_eos_r;
  // stage b: output word
  logic             out_valid_r;
  logic [15:0]      sample_r;
  logic             sv_r, last_r, eos_out_r;

  logic             adv;
  logic [CNT_W-1:0] n_req;
  logic             exhaust;
  logic [1:0]       quad;
  logic [QA_W-2:0]  idx;
  logic [QA_W-1:0]  rom_addr;
  logic [MAG_W-1:0] mag;
  logic             cfg_hit;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    if (clen_r == '0)                      n_req = CNT_W'(1);
    else if (clen_r > 7'(MAX_CHUNK))       n_req = CNT_W'(MAX_CHUNK);
    else                                   n_req = CNT_W'(clen_r);
  end

  assign exhaust = 32'(n_req) >= rem_r;

  assign sts.rem_zero = (rem_r == '0);
  assign sts.cnt_last = (cnt_r == CNT_W'(1));
  assign sts.advance  = adv;

  assign quad     = phase_r[31:30];
  assign idx      = phase_r[29 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (QA_W'(1 << SINE_TABLE_BITS) - {1'b0, idx}) : {1'b0, idx};

  always_comb begin
    case (cfg_index)
      REG_PHASE_INC, REG_START_PHASE, REG_STREAM_LEN, REG_CHUNK_LEN: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  stc_sine_rom u_rom (
    .clk  (clk),
    .en   (adv),
    .addr (rom_addr),
    .data (mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      clen_r  <= 7'(MAX_CHUNK);
      phase_r <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
      eos_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_INC:   inc_r   <= cfg_wdata;
          REG_START_PHASE: start_r <= cfg_wdata;
          REG_STREAM_LEN:  len_r   <= cfg_wdata;
          REG_CHUNK_LEN:   clen_r  <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      // any valid register write reloads phase and count from the new values
      if (cfg_hit) begin
        phase_r <= (cfg_index == REG_START_PHASE) ? cfg_wdata : start_r;
        rem_r   <= (cfg_index == REG_STREAM_LEN) ? cfg_wdata : len_r;
      end else if (cmd.start) begin
        if (rem_r == '0) begin
          eos_r <= 1'b1;
        end else if (exhaust) begin
          cnt_r <= CNT_W'(rem_r);
          rem_r <= '0;
          eos_r <= 1'b1;
        end else begin
          cnt_r <= n_req;
          rem_r <= rem_r - 32'(n_req);
          eos_r <= 1'b0;
        end
      end else if (cmd.issue) begin
        phase_r <= phase_r + inc_r;
        cnt_r   <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_vld_r     <= cmd.issue || cmd.issue_empty;
      out_valid_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg_r   <= quad[1];
      a_sv_r    <= cmd.issue;
      a_last_r  <= cmd.issue_empty || sts.cnt_last;
      a_eos_r   <= eos_r;
      sv_r      <= a_sv_r;
      last_r    <= a_last_r;
      eos_out_r <= a_eos_r;
      if (!a_sv_r)      sample_r <= '0;
      else if (a_neg_r) sample_r <= 16'd0 - {1'b0, mag};
      else              sample_r <= {1'b0, mag};
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = signed'(sample_r);
  assign out_sample_valid  = sv_r;
  assign out_last_of_chunk = last_r;
  assign out_end_of_stream = eos_out_r;

endmodule

@@ rtl/chunked_sine_tone_generator.sv @@
// top level of the chunked sine tone generator
// A request word on the in_ channel (in_valid, in_stall, in_chunk_request) asks for
// one chunk of sine samples; the block answers on the out_ channel with one word per
// sample: a Q1.15 sample, a sample-valid flag, a last-of-chunk flag and an
// end-of-stream flag. A request after the stream has run out gives one empty word
// with last-of-chunk and end-of-stream set. A request word with the bit clear is
// taken and gives nothing.
// The cfg_ port writes phase increment, start phase, stream length and chunk length;
// every write to one of them reloads the phase accumulator and the sample count.
// Write only while the block is idle.
// Timing: once the request is taken, the controller issues one sample per cycle while
// out_stall does not hold the pipeline; each sample passes the two-stage sine pipeline
// (rom read, then output register) before it is presented. The next request is taken
// once the last sample of the chunk has entered that pipeline. Throughput is one sample
// per cycle while the pipeline is not stalled, set by the single read port of the
// quarter-wave rom.
// While out_stall is high and a word is presented (out_valid high), the whole sample
// pipeline holds and no new sample issues. Reset (rst_n low, synchronous) clears the
// config and control registers to their defaults, empties the pipeline and leaves a stream of length zero.
module chunked_sine_tone_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_chunk_request,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_sample,
  output logic                          out_sample_valid,
  output logic                          out_last_of_chunk,
  output logic                          out_end_of_stream
);
  import stc_pkg::*;

  stc_cmd_t cmd;
  stc_sts_t sts;

  stc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_chunk_request (in_chunk_request),
    .sts              (sts),
    .cmd              (cmd)
  );

  stc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_sample_valid  (out_sample_valid),
    .out_last_of_chunk (out_last_of_chunk),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule
